@@ hdl/zsa_pkg.sv @@
// ----------------------------------------------------------------------------
// zsa_pkg
// Shared types and constants of the zonal statistics accumulator.
// ----------------------------------------------------------------------------
package zsa_pkg;

  localparam int ZONES_DEF   = 4096;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 24;
  localparam int SUM_BITS    = 40;
  localparam int SQ_BITS     = 54;
  localparam int ZCNT_BITS   = 13;
  localparam int ALU_W       = 80;

  localparam logic [ZCNT_BITS-1:0]  ZONE_COUNT_RST  = 13'd4096;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX       = '1;
  localparam logic [2:0]            ADDR_ZONE_COUNT = 3'd0;

  localparam logic [1:0] ACT_ACC   = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  typedef struct packed {
    logic [COUNT_BITS-1:0]         cnt;
    logic signed [SAMPLE_BITS-1:0] mn;
    logic signed [SAMPLE_BITS-1:0] mx;
    logic signed [SUM_BITS-1:0]    sum;
    logic [SQ_BITS-1:0]            sq;
  } row_t;

  typedef struct packed {
    logic                          empty_res;
    logic [COUNT_BITS-1:0]         cell_count;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic [15:0]                   spread;
    logic signed [SUM_BITS-1:0]    total;
    logic signed [15:0]            mean;
    logic [30:0]                   variance;
    logic [15:0]                   std_dev;
  } res_t;

  typedef enum logic [2:0] {
    ST_CLR, ST_IDLE, ST_LOOK, ST_FETCH, ST_STAT, ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    SQ_IDLE, SQ_NSQ, SQ_SSQ, SQ_NN, SQ_VDIV, SQ_MDIV, SQ_SQRT
  } seq_t;

endpackage

@@ hdl/zsa_alu.sv @@
// ----------------------------------------------------------------------------
// zsa_alu
// Shared wide adder/subtractor; the top bit is carry or borrow.
// ----------------------------------------------------------------------------
module zsa_alu (
  input  logic [zsa_pkg::ALU_W-1:0] a,
  input  logic [zsa_pkg::ALU_W-1:0] b,
  input  logic                      sub,
  output logic [zsa_pkg::ALU_W:0]   y
);

  always_comb begin
    if (sub) begin
      y = {1'b0, a} - {1'b0, b};
    end else begin
      y = {1'b0, a} + {1'b0, b};
    end
  end

endmodule

@@ hdl/zsa_stats.sv @@
// ----------------------------------------------------------------------------
// zsa_stats
// Read-side sequencer: shift-add products, restoring divisions and an
// integer square root, all through one shared adder/subtractor.
// ----------------------------------------------------------------------------
module zsa_stats (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  zsa_pkg::row_t row,
  output logic          done,
  output zsa_pkg::res_t res
);

  zsa_pkg::seq_t seq_r, seq_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [79:0] acc_r, acc_nxt;
  logic [79:0] opd_r, opd_nxt;
  logic [39:0] mlt_r, mlt_nxt;
  logic [47:0] dvs_r, dvs_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [30:0] var_r, var_nxt;
  logic [15:0] mean_r, mean_nxt;
  logic [23:0] n_r, n_nxt;
  logic [39:0] asum_r, asum_nxt;
  logic [39:0] sum_r, sum_nxt;
  logic [15:0] mn_r, mn_nxt;
  logic [15:0] mx_r, mx_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  zsa_pkg::res_t res_r, res_nxt;

  logic [79:0] alu_a, alu_b;
  logic        alu_sub;
  logic [80:0] alu_y;
  logic [48:0] rem_sh;
  logic        qbit;
  logic [79:0] acc_q;
  logic [48:0] rem_q;
  logic [39:0] root_q;

  zsa_alu u_alu (.a(alu_a), .b(alu_b), .sub(alu_sub), .y(alu_y));

  assign rem_sh = {rem_r[47:0], acc_r[79]};
  assign qbit   = ~alu_y[80];
  assign acc_q  = {acc_r[78:0], qbit};
  assign rem_q  = qbit ? alu_y[48:0] : rem_sh;
  assign root_q = qbit ? ({1'b0, mlt_r[39:1]} | dvs_r[39:0]) : {1'b0, mlt_r[39:1]};

  always_comb begin
    alu_a   = acc_r;
    alu_b   = opd_r;
    alu_sub = 1'b0;
    case (seq_r)
      zsa_pkg::SQ_SSQ: alu_sub = 1'b1;
      zsa_pkg::SQ_NN:  alu_a = {32'b0, dvs_r};
      zsa_pkg::SQ_VDIV, zsa_pkg::SQ_MDIV: begin
        alu_a   = {31'b0, rem_sh};
        alu_b   = {32'b0, dvs_r};
        alu_sub = 1'b1;
      end
      zsa_pkg::SQ_SQRT: begin
        // r and bit never overlap, so r + bit is r | bit
        alu_b   = {48'b0, mlt_r[31:0] | dvs_r[31:0]};
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    seq_nxt  = seq_r;
    cnt_nxt  = cnt_r - 7'd1;
    acc_nxt  = acc_r;
    opd_nxt  = opd_r;
    mlt_nxt  = mlt_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    var_nxt  = var_r;
    mean_nxt = mean_r;
    n_nxt    = n_r;
    asum_nxt = asum_r;
    sum_nxt  = sum_r;
    mn_nxt   = mn_r;
    mx_nxt   = mx_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    res_nxt  = res_r;
    case (seq_r)
      zsa_pkg::SQ_IDLE: begin
        cnt_nxt = cnt_r;
        if (start) begin
          n_nxt    = row.cnt;
          sum_nxt  = row.sum;
          mn_nxt   = row.mn;
          mx_nxt   = row.mx;
          neg_nxt  = row.sum[39];
          asum_nxt = row.sum[39] ? (~row.sum + 40'd1) : row.sum;
          acc_nxt  = '0;
          opd_nxt  = {26'b0, row.sq};
          mlt_nxt  = {16'b0, row.cnt};
          cnt_nxt  = 7'd23;
          seq_nxt  = zsa_pkg::SQ_NSQ;
        end
      end
      zsa_pkg::SQ_NSQ, zsa_pkg::SQ_SSQ: begin
        if (mlt_r[0]) begin
          acc_nxt = alu_y[79:0];
        end
        opd_nxt = {opd_r[78:0], 1'b0};
        mlt_nxt = {1'b0, mlt_r[39:1]};
        if (cnt_r == 7'd0) begin
          if (seq_r == zsa_pkg::SQ_NSQ) begin
            opd_nxt = {40'b0, asum_r};
            mlt_nxt = asum_r;
            cnt_nxt = 7'd39;
            seq_nxt = zsa_pkg::SQ_SSQ;
          end else begin
            opd_nxt = {56'b0, n_r};
            mlt_nxt = {16'b0, n_r};
            dvs_nxt = '0;
            cnt_nxt = 7'd23;
            seq_nxt = zsa_pkg::SQ_NN;
          end
        end
      end
      zsa_pkg::SQ_NN: begin
        if (mlt_r[0]) begin
          dvs_nxt = alu_y[47:0];
        end
        opd_nxt = {opd_r[78:0], 1'b0};
        mlt_nxt = {1'b0, mlt_r[39:1]};
        if (cnt_r == 7'd0) begin
          rem_nxt = '0;
          cnt_nxt = 7'd79;
          seq_nxt = zsa_pkg::SQ_VDIV;
        end
      end
      zsa_pkg::SQ_VDIV: begin
        acc_nxt = acc_q;
        rem_nxt = rem_q;
        if (cnt_r == 7'd0) begin
          var_nxt = acc_q[30:0];
          acc_nxt = {asum_r, 40'b0};
          rem_nxt = '0;
          dvs_nxt = {24'b0, n_r};
          cnt_nxt = 7'd39;
          seq_nxt = zsa_pkg::SQ_MDIV;
        end
      end
      zsa_pkg::SQ_MDIV: begin
        acc_nxt = acc_q;
        rem_nxt = rem_q;
        if (cnt_r == 7'd0) begin
          // floor of a negative quotient: -q, less one if a remainder is left
          mean_nxt = neg_r ? (~acc_q[15:0] + {15'b0, rem_q == 49'd0}) : acc_q[15:0];
          acc_nxt  = {49'b0, var_r};
          mlt_nxt  = '0;
          dvs_nxt  = {17'b0, 1'b1, 30'b0};
          cnt_nxt  = 7'd15;
          seq_nxt  = zsa_pkg::SQ_SQRT;
        end
      end
      zsa_pkg::SQ_SQRT: begin
        if (qbit) begin
          acc_nxt = alu_y[79:0];
        end
        mlt_nxt = root_q;
        dvs_nxt = {2'b0, dvs_r[47:2]};
        if (cnt_r == 7'd0) begin
          res_nxt.empty_res  = 1'b0;
          res_nxt.cell_count = n_r;
          res_nxt.minimum    = mn_r;
          res_nxt.maximum    = mx_r;
          res_nxt.spread     = mx_r - mn_r;
          res_nxt.total      = sum_r;
          res_nxt.mean       = mean_r;
          res_nxt.variance   = var_r;
          res_nxt.std_dev    = root_q[15:0];
          done_nxt           = 1'b1;
          seq_nxt            = zsa_pkg::SQ_IDLE;
        end
      end
      default: seq_nxt = zsa_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r  <= zsa_pkg::SQ_IDLE;
      done_r <= 1'b0;
    end else begin
      seq_r  <= seq_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    acc_r  <= acc_nxt;
    opd_r  <= opd_nxt;
    mlt_r  <= mlt_nxt;
    dvs_r  <= dvs_nxt;
    rem_r  <= rem_nxt;
    var_r  <= var_nxt;
    mean_r <= mean_nxt;
    n_r    <= n_nxt;
    asum_r <= asum_nxt;
    sum_r  <= sum_nxt;
    mn_r   <= mn_nxt;
    mx_r   <= mx_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

@@ hdl/zonal_statistics_accumulator.sv @@
// ----------------------------------------------------------------------------
// zonal_statistics_accumulator
// Per-zone count, min, max, sum and sum of squares with a statistics read.
// ----------------------------------------------------------------------------
// After reset the block sweeps its zone memory to zero, one zone per cycle,
// and takes no word meanwhile (register writes still go through). One item
// at a time: an accumulate or clear word is a read-modify-write of one
// memory row through the look and fetch states before the next word is
// taken; a read word of an in-range, non-empty zone runs the shared adder
// of the statistics unit through 24 + 40 + 24 multiply steps, 80 + 40
// divide steps and 16 root steps, then holds its result until it is taken.
module zonal_statistics_accumulator #(
  parameter int ZONES = zsa_pkg::ZONES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic signed [12:0] in_zone,
  input  logic signed [15:0] in_sample,
  input  logic               in_no_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_empty_res,
  output logic [23:0]        out_cell_count,
  output logic signed [15:0] out_minimum,
  output logic signed [15:0] out_maximum,
  output logic [15:0]        out_spread,
  output logic signed [39:0] out_total,
  output logic signed [15:0] out_mean,
  output logic [30:0]        out_variance,
  output logic [15:0]        out_std_dev
);

  localparam int ZW = $clog2(ZONES);
  localparam logic [ZW-1:0] LAST_ZONE = ZW'(ZONES - 1);

  zsa_pkg::state_t state_r, state_nxt;
  logic [ZW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [12:0]     zone_count_r;
  logic [1:0]      act_r;
  logic [ZW-1:0]   zidx_r;
  logic            ok_r;
  logic signed [15:0] sample_r;
  logic            nd_r;
  logic [31:0]     sq_r;
  zsa_pkg::row_t   row_q;
  zsa_pkg::res_t   res_r, res_nxt;

  zsa_pkg::row_t   mem [ZONES];
  logic            we, rd_en, start, done;
  logic [ZW-1:0]   waddr;
  zsa_pkg::row_t   wdata, acc_row;
  zsa_pkg::res_t   stat_res;
  logic [16:0]     zext;
  logic            zone_ok, take;
  logic signed [31:0] prod;

  zsa_stats u_stats (
    .clk(clk), .rst_n(rst_n), .start(start), .row(row_q), .done(done), .res(stat_res)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == zsa_pkg::ADDR_ZONE_COUNT) ? {19'b0, zone_count_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r <= zsa_pkg::ZONE_COUNT_RST;
    end else if (psel && penable && pwrite && paddr == zsa_pkg::ADDR_ZONE_COUNT) begin
      zone_count_r <= pwdata[12:0];
    end
  end

  // input capture
  assign in_stall = (state_r != zsa_pkg::ST_IDLE);
  assign take     = in_valid && !in_stall;
  assign zext     = {5'b0, in_zone[11:0]};
  assign zone_ok  = !in_zone[12] && ({1'b0, in_zone[11:0]} < zone_count_r)
                    && ({15'b0, zext} < 32'(ZONES));
  assign prod     = sample_r * sample_r;

  always_ff @(posedge clk) begin
    if (take) begin
      act_r    <= in_action;
      zidx_r   <= zone_ok ? zext[ZW-1:0] : '0;
      ok_r     <= zone_ok;
      sample_r <= in_sample;
      nd_r     <= in_no_data;
    end
    if (state_r == zsa_pkg::ST_LOOK) begin
      sq_r <= prod;
    end
  end

  // zone memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      row_q <= mem[zidx_r];
    end
  end

  // updated row for an accumulate word
  always_comb begin
    acc_row     = row_q;
    acc_row.cnt = row_q.cnt + 24'd1;
    acc_row.sum = row_q.sum + {{24{sample_r[15]}}, sample_r};
    acc_row.sq  = row_q.sq + {22'b0, sq_r};
    if (row_q.cnt == '0) begin
      acc_row.mn = sample_r;
      acc_row.mx = sample_r;
    end else begin
      if (sample_r < row_q.mn) acc_row.mn = sample_r;
      if (sample_r > row_q.mx) acc_row.mx = sample_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    we          = 1'b0;
    waddr       = zidx_r;
    wdata       = '0;
    rd_en       = 1'b0;
    start       = 1'b0;
    res_nxt     = res_r;
    case (state_r)
      zsa_pkg::ST_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt_r;
        if (clr_cnt_r == LAST_ZONE) begin
          state_nxt = zsa_pkg::ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      zsa_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = zsa_pkg::ST_LOOK;
      end
      zsa_pkg::ST_LOOK: begin
        rd_en     = 1'b1;
        state_nxt = zsa_pkg::ST_FETCH;
      end
      zsa_pkg::ST_FETCH: begin
        state_nxt = zsa_pkg::ST_IDLE;
        case (act_r)
          zsa_pkg::ACT_ACC: begin
            // drop no-data, out-of-range and saturated zones
            if (!nd_r && ok_r && row_q.cnt != zsa_pkg::COUNT_MAX) begin
              we    = 1'b1;
              wdata = acc_row;
            end
          end
          zsa_pkg::ACT_CLEAR: we = ok_r;
          zsa_pkg::ACT_READ: begin
            if (!ok_r || row_q.cnt == '0) begin
              res_nxt           = '0;
              res_nxt.empty_res = 1'b1;
              state_nxt         = zsa_pkg::ST_OUT;
            end else begin
              start     = 1'b1;
              state_nxt = zsa_pkg::ST_STAT;
            end
          end
          default: ;
        endcase
      end
      zsa_pkg::ST_STAT: begin
        if (done) begin
          res_nxt   = stat_res;
          state_nxt = zsa_pkg::ST_OUT;
        end
      end
      zsa_pkg::ST_OUT: begin
        if (!out_stall) state_nxt = zsa_pkg::ST_IDLE;
      end
      default: state_nxt = zsa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= zsa_pkg::ST_CLR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid      = (state_r == zsa_pkg::ST_OUT);
  assign out_empty_res  = res_r.empty_res;
  assign out_cell_count = res_r.cell_count;
  assign out_minimum    = res_r.minimum;
  assign out_maximum    = res_r.maximum;
  assign out_spread     = res_r.spread;
  assign out_total      = res_r.total;
  assign out_mean       = res_r.mean;
  assign out_variance   = res_r.variance;
  assign out_std_dev    = res_r.std_dev;

endmodule
